// ----- rtl/core/rar_pkg.sv -----
// Package of the rational arithmetic reducer: operation and status codes,
// sequencer state types and the default operand width.
// Used by rar_reduce, rational_arithmetic_reducer, rar_checker and tb_top.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ZERO  = 2'd1;
    localparam logic [1:0] STATUS_UNDEF = 2'd2;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_MUL,
        TOP_SUM,
        TOP_REDUCE,
        TOP_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        RED_IDLE,
        RED_GCD,
        RED_SHIFT,
        RED_DIV
    } red_state_t;

endpackage

// ----- rtl/core/rar_reduce.sv -----
// Reduction of a fraction to lowest terms: binary GCD, one step a cycle,
// then two bit-serial restoring divisions by the GCD.
// Depends on rar_pkg.
module rar_reduce
    import rar_pkg::*;
#(
    parameter int MAG_WIDTH = 2 * OPERAND_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MAG_WIDTH-1:0] num_in,
    input  logic [MAG_WIDTH-1:0] den_in,
    output logic                 done,
    output logic [MAG_WIDTH-1:0] num_out,
    output logic [MAG_WIDTH-1:0] den_out
);

    localparam int KW = $clog2(MAG_WIDTH + 1);

    red_state_t state_reg, state_next;

    logic [MAG_WIDTH-1:0] a_reg, b_reg, g_reg, nv_reg, dv_reg, rn_reg, rd_reg;
    logic [KW-1:0]        k_reg, cnt_reg;
    logic                 done_reg;

    logic [MAG_WIDTH:0]   rn_try, rd_try, g_ext;

    assign g_ext  = {1'b0, g_reg};
    assign rn_try = {rn_reg, nv_reg[MAG_WIDTH-1]};
    assign rd_try = {rd_reg, dv_reg[MAG_WIDTH-1]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RED_IDLE:  if (start) state_next = RED_GCD;
            RED_GCD:   if (a_reg == '0 || b_reg == '0) state_next = RED_SHIFT;
            RED_SHIFT: if (k_reg == '0) state_next = RED_DIV;
            RED_DIV:   if (cnt_reg == KW'(1)) state_next = RED_IDLE;
            default:   state_next = RED_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RED_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RED_DIV) && (cnt_reg == KW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            RED_IDLE: begin
                if (start) begin
                    a_reg  <= num_in;
                    b_reg  <= den_in;
                    nv_reg <= num_in;
                    dv_reg <= den_in;
                    k_reg  <= '0;
                end
            end
            RED_GCD: begin
                if (a_reg == '0 || b_reg == '0) begin
                    g_reg <= a_reg | b_reg;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + KW'(1);
                end else if (!a_reg[0]) begin
                    a_reg <= a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_reg <= b_reg >> 1;
                end else if (a_reg >= b_reg) begin
                    a_reg <= a_reg - b_reg;
                end else begin
                    b_reg <= b_reg - a_reg;
                end
            end
            RED_SHIFT: begin
                if (k_reg == '0) begin
                    cnt_reg <= KW'(MAG_WIDTH);
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                end else begin
                    g_reg <= g_reg << 1;
                    k_reg <= k_reg - KW'(1);
                end
            end
            RED_DIV: begin
                // Dividend registers shift out their top bit and take in quotient bits.
                if (rn_try >= g_ext) begin
                    rn_reg <= MAG_WIDTH'(rn_try - g_ext);
                    nv_reg <= {nv_reg[MAG_WIDTH-2:0], 1'b1};
                end else begin
                    rn_reg <= rn_try[MAG_WIDTH-1:0];
                    nv_reg <= {nv_reg[MAG_WIDTH-2:0], 1'b0};
                end
                if (rd_try >= g_ext) begin
                    rd_reg <= MAG_WIDTH'(rd_try - g_ext);
                    dv_reg <= {dv_reg[MAG_WIDTH-2:0], 1'b1};
                end else begin
                    rd_reg <= rd_try[MAG_WIDTH-1:0];
                    dv_reg <= {dv_reg[MAG_WIDTH-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - KW'(1);
            end
            default: ;
        endcase
    end

    assign done    = done_reg;
    assign num_out = nv_reg;
    assign den_out = dv_reg;

endmodule

// ----- rtl/core/rational_arithmetic_reducer.sv -----
// Top level of the rational arithmetic reducer: operand capture, serial
// multipliers, signed combine and the output register.
// Depends on rar_pkg and rar_reduce.
//
// Usage: one input item on the s_ channel carries an operation (s_tuser) and
// two fractions num_a/den_a and num_b/den_b (s_tdata). One result item leaves
// on the m_ channel with a status and the sign (m_tuser) and the reduced
// numerator and denominator magnitudes (m_tdata).
// The block works on one item at a time. s_tready is high only while the
// sequencer is idle. An item is accepted, runs through the shift-add
// multipliers and is combined, then goes through the binary GCD (one
// subtract or shift per cycle), the scaling of the GCD back up by the
// common factors of two, the two serial divisions and the hand-over of
// the result. Undefined results skip the arithmetic; a zero numerator
// skips the reduction.
// Reset clears the sequencer and the output valid; the data
// registers are not reset.
// While the receiver stalls, the finished result waits in the output
// register; the next item is still accepted and computed, and its result
// waits in the sequencer until the output register has been taken.
module rational_arithmetic_reducer
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // num_a [15:0], den_a [31:16], num_b [47:32], den_b [63:48]
    input  logic [63:0] s_tdata,
    // kind [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // num_mag [31:0], den_mag [62:32], padding [63]
    output logic [63:0] m_tdata,
    // status [1:0], negative [2]
    output logic [2:0]  m_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int CW = $clog2(W + 1);

    top_state_t state_reg, state_next;

    logic [W-1:0] na, da, nb, db;
    logic [W-1:0] ma_n, ma_d, mb_n, mb_d;
    logic [W-1:0] x1, y1, x2, y2, xd, yd;
    logic         s1, s2, sd, undef_in;

    logic [MW-1:0] c1_reg, c2_reg, cd_reg, p1_reg, p2_reg, pd_reg;
    logic [W-1:0]  m1_reg, m2_reg, md_reg;
    logic [CW-1:0] cnt_reg;
    logic          s1_reg, s2_reg, sd_reg;

    logic [MW-1:0] sum_mag;
    logic          sum_sign, neg_reg;
    logic [1:0]    status_reg;

    logic          red_start, red_done;
    logic [MW-1:0] red_num, red_den, qn_reg, qd_reg;

    logic          m_tvalid_reg, load_out;
    logic [1:0]    out_status_reg;
    logic          out_neg_reg;
    logic [31:0]   out_num_reg;
    logic [30:0]   out_den_reg;

    assign na = W'(s_tdata[15:0]);
    assign da = W'(s_tdata[31:16]);
    assign nb = W'(s_tdata[47:32]);
    assign db = W'(s_tdata[63:48]);

    assign ma_n = na[W-1] ? W'(-na) : na;
    assign ma_d = da[W-1] ? W'(-da) : da;
    assign mb_n = nb[W-1] ? W'(-nb) : nb;
    assign mb_d = db[W-1] ? W'(-db) : db;

    always_comb begin
        x1 = ma_n;
        y1 = mb_d;
        x2 = mb_n;
        y2 = ma_d;
        xd = ma_d;
        yd = mb_d;
        s1 = na[W-1] ^ db[W-1];
        s2 = nb[W-1] ^ da[W-1];
        sd = da[W-1] ^ db[W-1];
        case (s_tuser)
            KIND_SUB: s2 = ~s2;
            KIND_MUL: begin
                y1 = mb_n;
                x2 = '0;
                s1 = na[W-1] ^ nb[W-1];
            end
            KIND_DIV: begin
                x2 = '0;
                yd = mb_n;
                sd = da[W-1] ^ nb[W-1];
            end
            default: ;
        endcase
    end

    // Undefined if an input denominator is zero, or if a zero divisor in a division gives a zero denominator.
    assign undef_in = (da == '0) || (db == '0) || ((s_tuser == KIND_DIV) && (nb == '0));

    // Signed-magnitude sum of the two cross products.
    always_comb begin
        if (s1_reg == s2_reg) begin
            sum_mag  = p1_reg + p2_reg;
            sum_sign = s1_reg;
        end else if (p1_reg >= p2_reg) begin
            sum_mag  = p1_reg - p2_reg;
            sum_sign = s1_reg;
        end else begin
            sum_mag  = p2_reg - p1_reg;
            sum_sign = s2_reg;
        end
    end

    assign load_out = (state_reg == TOP_HOLD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE:   if (s_tvalid) state_next = undef_in ? TOP_HOLD : TOP_MUL;
            TOP_MUL:    if (cnt_reg == CW'(1)) state_next = TOP_SUM;
            TOP_SUM:    state_next = (sum_mag == '0) ? TOP_HOLD : TOP_REDUCE;
            TOP_REDUCE: if (red_done) state_next = TOP_HOLD;
            TOP_HOLD:   if (load_out) state_next = TOP_IDLE;
            default:    state_next = TOP_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == TOP_IDLE);
        red_start = (state_reg == TOP_SUM) && (sum_mag != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TOP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            TOP_IDLE: begin
                if (s_tvalid) begin
                    c1_reg     <= MW'(x1);
                    c2_reg     <= MW'(x2);
                    cd_reg     <= MW'(xd);
                    m1_reg     <= y1;
                    m2_reg     <= y2;
                    md_reg     <= yd;
                    p1_reg     <= '0;
                    p2_reg     <= '0;
                    pd_reg     <= '0;
                    s1_reg     <= s1;
                    s2_reg     <= s2;
                    sd_reg     <= sd;
                    cnt_reg    <= CW'(W);
                    status_reg <= STATUS_UNDEF;
                end
            end
            TOP_MUL: begin
                if (m1_reg[0]) p1_reg <= p1_reg + c1_reg;
                if (m2_reg[0]) p2_reg <= p2_reg + c2_reg;
                if (md_reg[0]) pd_reg <= pd_reg + cd_reg;
                c1_reg  <= c1_reg << 1;
                c2_reg  <= c2_reg << 1;
                cd_reg  <= cd_reg << 1;
                m1_reg  <= m1_reg >> 1;
                m2_reg  <= m2_reg >> 1;
                md_reg  <= md_reg >> 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            TOP_SUM: begin
                neg_reg    <= sum_sign ^ sd_reg;
                status_reg <= (sum_mag == '0) ? STATUS_ZERO : STATUS_OK;
            end
            TOP_REDUCE: begin
                if (red_done) begin
                    qn_reg <= red_num;
                    qd_reg <= red_den;
                end
            end
            default: ;
        endcase
        if (load_out) begin
            out_status_reg <= status_reg;
            unique case (status_reg)
                STATUS_OK: begin
                    out_neg_reg <= neg_reg;
                    out_num_reg <= 32'(qn_reg);
                    out_den_reg <= 31'(qd_reg);
                end
                STATUS_ZERO: begin
                    out_neg_reg <= 1'b0;
                    out_num_reg <= '0;
                    out_den_reg <= 31'd1;
                end
                default: begin
                    out_neg_reg <= 1'b0;
                    out_num_reg <= '0;
                    out_den_reg <= '0;
                end
            endcase
        end
    end

    rar_reduce #(
        .MAG_WIDTH(MW)
    ) u_reduce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .num_in  (sum_mag),
        .den_in  (pd_reg),
        .done    (red_done),
        .num_out (red_num),
        .den_out (red_den)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_den_reg, out_num_reg};
    assign m_tuser  = {out_neg_reg, out_status_reg};

endmodule

// ----- verif/rar_checker.sv -----
// Checker of the rational arithmetic reducer: watches both channels, predicts
// each result from the accepted input item and compares it field by field.
// Depends on rar_pkg.
module rar_checker
    import rar_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic        negative;
        logic [31:0] num_mag;
        logic [30:0] den_mag;
    } fraction_t;

    fraction_t reduced_q[$];

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic fraction_t reduce_fraction(logic [1:0] kind, logic [63:0] d);
        longint na, da, nb, db, n, q;
        longint unsigned mn, md, x, y, t;
        fraction_t r;
        na = longint'($signed(d[15:0]));
        da = longint'($signed(d[31:16]));
        nb = longint'($signed(d[47:32]));
        db = longint'($signed(d[63:48]));
        r = '0;
        if (da == 0 || db == 0) begin
            r.status = STATUS_UNDEF;
            return r;
        end
        case (kind)
            KIND_ADD: begin n = na * db + nb * da; q = da * db; end
            KIND_SUB: begin n = na * db - nb * da; q = da * db; end
            KIND_MUL: begin n = na * nb; q = da * db; end
            default:  begin n = na * db; q = da * nb; end
        endcase
        if (q == 0) begin
            r.status = STATUS_UNDEF;
            return r;
        end
        if (n == 0) begin
            r.status = STATUS_ZERO;
            r.den_mag = 31'd1;
            return r;
        end
        mn = abs64(n);
        md = abs64(q);
        x = mn;
        y = md;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        r.status = STATUS_OK;
        r.negative = (n < 0) != (q < 0);
        r.num_mag = 32'(mn / x);
        r.den_mag = 31'(md / x);
        return r;
    endfunction

    assign pending = reduced_q.size();

    always @(posedge aclk) begin
        fraction_t want;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_tvalid && s_tready)
                reduced_q.push_back(reduce_fraction(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (reduced_q.size() == 0) begin
                    $display("%0t: unexpected result tdata %h tuser %h", $time,
                             m_tdata, m_tuser);
                    errors <= errors + 1;
                end else begin
                    want = reduced_q.pop_front();
                    if (m_tuser[1:0] !== want.status || m_tuser[2] !== want.negative ||
                        m_tdata[31:0] !== want.num_mag ||
                        m_tdata[62:32] !== want.den_mag) begin
                        $display("%0t: expected st %0d neg %0d %0d/%0d, actual st %0d neg %0d %0d/%0d",
                                 $time, want.status, want.negative, want.num_mag,
                                 want.den_mag, m_tuser[1:0], m_tuser[2],
                                 m_tdata[31:0], m_tdata[62:32]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top of the rational arithmetic reducer: clock, reset, directed and
// random stimulus with bursty input and a stalling receiver, and the verdict.
// Depends on rar_pkg, rational_arithmetic_reducer and rar_checker.
module tb_top;
    import rar_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    int          errors;
    int          pending;
    bit          hold_off;
    bit          stall_done;

    rational_arithmetic_reducer dut (.*);
    rar_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("rational_arithmetic_reducer: mismatch");
        $finish;
    end

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 6)) - 3);
            4, 5: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom());
        endcase
    endfunction

    // Offers one item and holds it until the block takes it.
    task automatic send_fraction(logic [1:0] kind, logic [15:0] na, logic [15:0] da,
                                 logic [15:0] nb, logic [15:0] db);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {db, nb, da, na};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pause_input(int cycles);
        s_tvalid <= 1'b0;
        s_tdata <= 64'($urandom()) << 32 | 64'($urandom());
        repeat (cycles) @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off, and calm stretches.
    initial begin
        int phase;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off && !stall_done) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                stall_done = 1;
            end
            phase++;
            if ((phase / 500) % 3 == 2) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        int n;
        bit drained;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        aresetn = 1'b0;
        drained = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int k = 0; k < 4; k++) begin
            send_fraction(2'(k), 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
            send_fraction(2'(k), 16'h7fff, 16'h8001, 16'h8000, 16'h8000);
            send_fraction(2'(k), 16'd3, 16'd0, 16'd1, 16'd2);
            send_fraction(2'(k), 16'd1, 16'd2, 16'd1, 16'd0);
            send_fraction(2'(k), 16'd1, 16'd2, 16'd0, 16'hffff);
        end
        // Zero sum, zero difference, and divide by a zero fraction.
        send_fraction(KIND_ADD, 16'd1, 16'd2, 16'hffff, 16'd2);
        send_fraction(KIND_SUB, 16'd5, 16'd7, 16'd10, 16'd14);
        send_fraction(KIND_DIV, 16'd0, 16'd3, 16'd0, 16'd5);
        send_fraction(KIND_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_fraction(KIND_DIV, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
        n = 0;
        while (n < 1950) begin
            int burst;
            burst = $urandom_range(1, 12);
            if (n >= 600) hold_off = 1;
            if (n >= 1200 && !drained) begin
                drained = 1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            for (int i = 0; i < burst; i++) begin
                send_fraction(2'($urandom()), pick_operand(), pick_operand(),
                              pick_operand(), pick_operand());
                n++;
            end
            if ($urandom_range(0, 2) == 0) pause_input($urandom_range(1, 200));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("rational_arithmetic_reducer: match");
        end else begin
            $display("rational_arithmetic_reducer: mismatch");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/rar_pkg.sv
rtl/core/rar_reduce.sv
rtl/core/rational_arithmetic_reducer.sv
verif/rar_checker.sv
verif/tb_top.sv
